/* sv/macc_pkg.sv */
// ----------------------------------------------------------------------------
// macc_pkg: shared types and constants of the checksum engine
// Algorithm codes, register indexes, hash primes and a rotate helper.
// ----------------------------------------------------------------------------
package macc_pkg;

	typedef logic [1:0]  cfg_idx_t;
	typedef logic [1:0]  alg_t;
	typedef logic [31:0] word_t;

	localparam alg_t ALG_ADLER = 2'd0;
	localparam alg_t ALG_CRC   = 2'd1;
	localparam alg_t ALG_XXH   = 2'd2;
	localparam alg_t ALG_NONE  = 2'd3;

	localparam cfg_idx_t REG_ALGORITHM = 2'd0;
	localparam cfg_idx_t REG_START     = 2'd1;
	localparam cfg_idx_t REG_USE_START = 2'd2;

	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam word_t CRC_POLY = 32'hEDB88320;
	localparam word_t XP1 = 32'd2654435761;
	localparam word_t XP2 = 32'd2246822519;
	localparam word_t XP3 = 32'd3266489917;
	localparam word_t XP4 = 32'd668265263;
	localparam word_t XP5 = 32'd374761393;

	function automatic word_t rotl32(input word_t v, input logic [4:0] n);
		return (v << n) | (v >> (6'd32 - {1'b0, n}));
	endfunction

endpackage

/* sv/macc_if.sv */
// ----------------------------------------------------------------------------
// macc channel interfaces
// Byte stream in, digest out and register write channel.
// ----------------------------------------------------------------------------
interface macc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface macc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest;
	logic        no_algorithm;
	modport source (output valid, output digest, output no_algorithm, input ready);
	modport sink   (input valid, input digest, input no_algorithm, output ready);
endinterface

interface macc_cfg_if;
	logic               valid;
	logic               ready;
	macc_pkg::cfg_idx_t index;
	logic [31:0]        data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/multi_algorithm_checksum_engine_top.sv */
// ----------------------------------------------------------------------------
// multi_algorithm_checksum_engine_top: Adler-32 / CRC-32 / xxHash32 digest
// Byte-serial checksum engine with one shared 32x32 multiplier sequenced
// over the xxHash32 lane rounds, tail rounds and avalanche.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload                 | accepted when
//  src     | in  | data_byte[7:0], last         | src.valid & src.ready
//  dst     | out | digest[31:0], no_algorithm   | dst.valid & dst.ready
//  cfg     | in  | index[1:0], data[31:0]       | cfg.valid & cfg.ready (always ready)
//
//  Work per byte: Adler-32 folds a byte in as it is taken; CRC-32 then shifts
//  it in one bit per cycle in the shift unit. xxHash32 takes each byte into
//  the stripe buffer, and every 16th byte also runs four lane rounds through
//  the single multiplier. Finalization for xxHash32 runs S_FINIT and S_FSUM,
//  stripe alignment, a round per tail word or byte and the avalanche; the tail
//  rounds and avalanche use the same multiplier. Every digest then moves from S_EMIT into the output register.
//  Reset clears the configuration to "no algorithm", seed 0. src.ready drops
//  while a byte is being worked; the digest register lets the next message
//  start while a finished digest still waits on dst.
// ----------------------------------------------------------------------------
module multi_algorithm_checksum_engine_top (
	input  logic               clk,
	input  logic               arst_n,
	macc_in_if.sink            src,
	macc_out_if.source         dst,
	macc_cfg_if.sink           cfg
);
	import macc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CRC, S_LANE, S_R1, S_R2, S_R3, S_R4,
		S_FINIT, S_FSUM, S_ALIGN, S_TAIL,
		S_AV0, S_AV1, S_AV2, S_AV3, S_AV4, S_EMIT
	} state_t;

	typedef enum logic [1:0] {K_LANE, K_TWORD, K_TBYTE} kind_t;

	state_t            state_q;
	kind_t             kind_q;
	alg_t              alg_q;
	word_t             start_q;
	logic              use_q;
	word_t             running_q;
	logic [3:0][31:0]  lane_q;
	logic [15:0][7:0]  stripe_q;
	logic [3:0]        fill_q;
	word_t             total_q;
	logic              seen_q;
	logic [2:0]        cnt_q;
	logic [1:0]        lane_i_q;
	logic [3:0]        left_q;
	logic [3:0]        pos_q;
	logic              last_q;
	word_t             x_q;
	word_t             p_q;
	word_t             h_q;
	word_t             res_q;
	logic              none_q;
	logic              out_valid_q;
	word_t             out_digest_q;
	logic              out_none_q;

	logic        in_fire;
	logic        cfg_fire;
	alg_t        alg_n;
	word_t       start_n;
	logic        use_n;
	word_t       rs_running;
	logic [16:0] ad_s1;
	logic [15:0] ad_s1r;
	logic [16:0] ad_s2;
	logic [16:0] ad_t;
	logic [16:0] ad_t2;
	word_t       adler_nx;
	word_t       crc_nx;
	word_t       total_nx;
	word_t       mul_k;
	logic [63:0] mul_full;
	word_t       rnd_base;
	logic [4:0]  rnd_rot;
	logic [4:0]  fsum_rot;
	word_t       fsum_term;

	assign src.ready        = (state_q == S_IDLE);
	assign cfg.ready        = 1'b1;
	assign dst.valid        = out_valid_q;
	assign dst.digest       = out_digest_q;
	assign dst.no_algorithm = out_none_q;

	assign in_fire  = src.valid && src.ready;
	assign cfg_fire = cfg.valid && cfg.ready;

	// Configuration as it stands after this cycle's write; a restart uses it.
	always_comb begin
		alg_n   = alg_q;
		start_n = start_q;
		use_n   = use_q;
		if (cfg_fire) begin
			case (cfg.index)
				REG_ALGORITHM: alg_n   = cfg.data[1:0];
				REG_START:     start_n = cfg.data;
				REG_USE_START: use_n   = cfg.data[0];
				default:       ;
			endcase
		end
		if (use_n)
			rs_running = start_n;
		else
			rs_running = (alg_n == ALG_ADLER) ? 32'd1 : 32'd0;
	end

	// Adler-32 byte step: one conditional subtract of the modulus for the low sum, two for the high sum.
	always_comb begin
		ad_s1  = {1'b0, running_q[15:0]} + {9'd0, src.data_byte};
		ad_s1r = (ad_s1 >= ADLER_MOD) ? 16'(ad_s1 - ADLER_MOD) : ad_s1[15:0];
		ad_s2  = {1'b0, running_q[31:16]} + {1'b0, ad_s1r};
		ad_t   = (ad_s2 >= ADLER_MOD) ? (ad_s2 - ADLER_MOD) : ad_s2;
		ad_t2  = (ad_t >= ADLER_MOD) ? (ad_t - ADLER_MOD) : ad_t;
		adler_nx = {ad_t2[15:0], ad_s1r};
	end

	// CRC-32 reflected, one bit per cycle.
	assign crc_nx   = x_q[0] ? ((x_q >> 1) ^ CRC_POLY) : (x_q >> 1);
	assign total_nx = total_q + 32'd1;

	// Shared multiplier: constant picked by the sequencer step.
	always_comb begin
		case (state_q)
			S_R1: begin
				case (kind_q)
					K_LANE:  mul_k = XP2;
					K_TWORD: mul_k = XP3;
					default: mul_k = XP5;
				endcase
			end
			S_R3:    mul_k = (kind_q == K_TWORD) ? XP4 : XP1;
			S_AV1:   mul_k = XP2;
			S_AV3:   mul_k = XP3;
			default: mul_k = XP1;
		endcase
	end
	assign mul_full = x_q * mul_k;

	always_comb begin
		rnd_base = (kind_q == K_LANE) ? lane_q[0] : h_q;
		case (kind_q)
			K_LANE:  rnd_rot = 5'd13;
			K_TWORD: rnd_rot = 5'd17;
			default: rnd_rot = 5'd11;
		endcase
		case (cnt_q[1:0])
			2'd0:    fsum_rot = 5'd7;
			2'd1:    fsum_rot = 5'd12;
			default: fsum_rot = 5'd18;
		endcase
		if (cnt_q[1:0] == 2'd3)
			fsum_term = total_q;
		else
			fsum_term = seen_q ? rotl32(lane_q[0], fsum_rot) : 32'd0;
	end

	// Stripe buffer: bytes enter at the top and move down, oldest at entry 0.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire && alg_q == ALG_XXH)
					stripe_q <= {src.data_byte, stripe_q[15:1]};
			end
			S_LANE:  stripe_q <= {stripe_q[3:0], stripe_q[15:4]};
			S_ALIGN: stripe_q <= {stripe_q[0], stripe_q[15:1]};
			S_TAIL: begin
				if (left_q >= 4'd4)
					stripe_q <= {stripe_q[3:0], stripe_q[15:4]};
				else if (left_q != 4'd0)
					stripe_q <= {stripe_q[0], stripe_q[15:1]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= K_LANE;
			alg_q        <= ALG_NONE;
			start_q      <= '0;
			use_q        <= 1'b0;
			running_q    <= '0;
			lane_q       <= {-XP1, 32'd0, XP2, XP1 + XP2};
			fill_q       <= '0;
			total_q      <= '0;
			seen_q       <= 1'b0;
			cnt_q        <= '0;
			lane_i_q     <= '0;
			left_q       <= '0;
			pos_q        <= '0;
			last_q       <= 1'b0;
			x_q          <= '0;
			p_q          <= '0;
			h_q          <= '0;
			res_q        <= '0;
			none_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_digest_q <= '0;
			out_none_q   <= 1'b0;
		end else begin
			if (out_valid_q && dst.ready)
				out_valid_q <= 1'b0;

			// A register write restarts the message from the new configuration.
			if (cfg_fire && (cfg.index inside {REG_ALGORITHM, REG_START, REG_USE_START})) begin
				alg_q     <= alg_n;
				start_q   <= start_n;
				use_q     <= use_n;
				running_q <= rs_running;
				lane_q    <= {start_n - XP1, start_n, start_n + XP2, start_n + XP1 + XP2};
				fill_q    <= '0;
				total_q   <= '0;
				seen_q    <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q <= src.last;
						case (alg_q)
							ALG_ADLER: begin
								running_q <= adler_nx;
								if (src.last) begin
									res_q   <= adler_nx;
									none_q  <= 1'b0;
									state_q <= S_EMIT;
								end
							end
							ALG_CRC: begin
								x_q     <= ~running_q ^ {24'd0, src.data_byte};
								cnt_q   <= '0;
								state_q <= S_CRC;
							end
							ALG_XXH: begin
								total_q <= total_nx;
								seen_q  <= seen_q | (total_nx >= 32'd16);
								if (fill_q == 4'd15) begin
									fill_q   <= '0;
									lane_i_q <= '0;
									state_q  <= S_LANE;
								end else begin
									fill_q <= fill_q + 4'd1;
									if (src.last)
										state_q <= S_FINIT;
								end
							end
							default: begin
								if (src.last) begin
									res_q   <= '0;
									none_q  <= 1'b1;
									state_q <= S_EMIT;
								end
							end
						endcase
					end
				end
				S_CRC: begin
					x_q   <= crc_nx;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						running_q <= ~crc_nx;
						if (last_q) begin
							res_q   <= ~crc_nx;
							none_q  <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				// Lane round: lane 0 always works; lanes rotate after each round.
				S_LANE: begin
					x_q     <= stripe_q[3:0];
					kind_q  <= K_LANE;
					state_q <= S_R1;
				end
				S_R1: begin
					p_q     <= mul_full[31:0];
					state_q <= S_R2;
				end
				S_R2: begin
					x_q     <= rotl32(rnd_base + p_q, rnd_rot);
					state_q <= S_R3;
				end
				S_R3: begin
					p_q     <= mul_full[31:0];
					state_q <= S_R4;
				end
				S_R4: begin
					if (kind_q == K_LANE) begin
						lane_q   <= {p_q, lane_q[3:1]};
						lane_i_q <= lane_i_q + 2'd1;
						if (lane_i_q == 2'd3)
							state_q <= last_q ? S_FINIT : S_IDLE;
						else
							state_q <= S_LANE;
					end else begin
						h_q     <= p_q;
						state_q <= S_TAIL;
					end
				end
				S_FINIT: begin
					h_q     <= seen_q ? rotl32(lane_q[0], 5'd1) : lane_q[2] + XP5;
					lane_q  <= {lane_q[0], lane_q[3:1]};
					cnt_q   <= '0;
					state_q <= S_FSUM;
				end
				// Add the other three rotated lanes (zero before a full stripe), then the length.
				S_FSUM: begin
					h_q    <= h_q + fsum_term;
					lane_q <= {lane_q[0], lane_q[3:1]};
					cnt_q  <= cnt_q + 3'd1;
					if (cnt_q[1:0] == 2'd3) begin
						left_q  <= fill_q;
						pos_q   <= -fill_q;
						state_q <= (fill_q == 4'd0) ? S_AV0 : S_ALIGN;
					end
				end
				// Move the partial stripe down so its first byte sits at entry 0.
				S_ALIGN: begin
					pos_q <= pos_q - 4'd1;
					if (pos_q == 4'd1)
						state_q <= S_TAIL;
				end
				S_TAIL: begin
					if (left_q == 4'd0) begin
						state_q <= S_AV0;
					end else if (left_q >= 4'd4) begin
						x_q     <= stripe_q[3:0];
						left_q  <= left_q - 4'd4;
						kind_q  <= K_TWORD;
						state_q <= S_R1;
					end else begin
						x_q     <= {24'd0, stripe_q[0]};
						left_q  <= left_q - 4'd1;
						kind_q  <= K_TBYTE;
						state_q <= S_R1;
					end
				end
				S_AV0: begin
					x_q     <= h_q ^ (h_q >> 15);
					state_q <= S_AV1;
				end
				S_AV1: begin
					p_q     <= mul_full[31:0];
					state_q <= S_AV2;
				end
				S_AV2: begin
					x_q     <= p_q ^ (p_q >> 13);
					state_q <= S_AV3;
				end
				S_AV3: begin
					p_q     <= mul_full[31:0];
					state_q <= S_AV4;
				end
				S_AV4: begin
					res_q   <= p_q ^ (p_q >> 16);
					none_q  <= 1'b0;
					state_q <= S_EMIT;
				end
				// Hold the digest until the output register frees, then restart.
				S_EMIT: begin
					if (!out_valid_q || dst.ready) begin
						out_valid_q  <= 1'b1;
						out_digest_q <= res_q;
						out_none_q   <= none_q;
						running_q    <= rs_running;
						lane_q       <= {start_q - XP1, start_q, start_q + XP2,
							start_q + XP1 + XP2};
						fill_q       <= '0;
						total_q      <= '0;
						seen_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sim/multi_algorithm_checksum_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_algorithm_checksum_engine_top_tb: digest regression bench
// Streams messages under each checksum algorithm and several start
// settings. A scoreboard predicts every digest and compares the results
// in order, while both ends stall at random.
// ----------------------------------------------------------------------------
module multi_algorithm_checksum_engine_top_tb;
	import macc_pkg::*;

	// register index with no register behind it
	localparam cfg_idx_t REG_SPARE = 2'd3;
	localparam int MAX_GAP = 18;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 150;

	// ------------------------------------------------------------------
	// Digest predictor and in-order result store
	// ------------------------------------------------------------------
	class digest_scoreboard;
		alg_t        alg;
		word_t       start;
		bit          use_start;
		word_t       sum;
		word_t       lane[4];
		logic [7:0]  stripe[16];
		int          fill;
		word_t       total;
		bit          full_seen;
		word_t       want_digest[$];
		bit          want_none[$];
		int          errors;

		function new();
			alg = ALG_NONE;
			start = '0;
			use_start = 1'b0;
			errors = 0;
			restart();
		endfunction

		function word_t rol(word_t v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function word_t word_at(int pos);
			return {stripe[(pos + 3) & 15], stripe[(pos + 2) & 15],
				stripe[(pos + 1) & 15], stripe[pos & 15]};
		endfunction

		function void restart();
			if (use_start)
				sum = start;
			else
				sum = (alg == ALG_ADLER) ? 32'd1 : 32'd0;
			lane[0] = start + XP1 + XP2;
			lane[1] = start + XP2;
			lane[2] = start;
			lane[3] = start - XP1;
			foreach (stripe[i]) stripe[i] = '0;
			fill = 0;
			total = '0;
			full_seen = 1'b0;
		endfunction

		// a write to any of the three registers restarts the message in progress
		function void write_reg(cfg_idx_t idx, word_t v);
			case (idx)
				REG_ALGORITHM: alg = v[1:0];
				REG_START:     start = v;
				REG_USE_START: use_start = v[0];
				default:       return;
			endcase
			restart();
		endfunction

		function word_t xxh_digest();
			word_t h;
			int pos;
			int left;
			pos = 0;
			left = fill;
			if (full_seen)
				h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
			else
				h = lane[2] + XP5;
			h += total;
			while (left >= 4) begin
				h += word_at(pos) * XP3;
				h = rol(h, 17) * XP4;
				pos += 4;
				left -= 4;
			end
			while (left != 0) begin
				h += word_t'(stripe[pos]) * XP5;
				h = rol(h, 11) * XP1;
				pos++;
				left--;
			end
			h ^= h >> 15;
			h *= XP2;
			h ^= h >> 13;
			h *= XP3;
			h ^= h >> 16;
			return h;
		endfunction

		// note an accepted byte; queue a digest when it closes the message
		function void take_byte(logic [7:0] b, bit last);
			logic [31:0] s1;
			logic [31:0] s2;
			word_t r;
			word_t v;
			case (alg)
				ALG_ADLER: begin
					s1 = (sum[15:0] + b) % 65521;
					s2 = (sum[31:16] + s1) % 65521;
					sum = (s2 << 16) + s1;
				end
				ALG_CRC: begin
					r = ~sum ^ word_t'(b);
					for (int i = 0; i < 8; i++)
						r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
					sum = ~r;
				end
				ALG_XXH: begin
					total += 1;
					if (total >= 16)
						full_seen = 1'b1;
					stripe[fill] = b;
					fill++;
					if (fill == 16) begin
						for (int i = 0; i < 4; i++) begin
							v = lane[i] + word_at(i * 4) * XP2;
							lane[i] = rol(v, 13) * XP1;
						end
						fill = 0;
					end
				end
				default: ;
			endcase
			if (!last)
				return;
			if (alg == ALG_ADLER || alg == ALG_CRC)
				want_digest.push_back(sum);
			else if (alg == ALG_XXH)
				want_digest.push_back(xxh_digest());
			else
				want_digest.push_back('0);
			want_none.push_back(alg == ALG_NONE);
			restart();
		endfunction

		function void check(word_t dg, bit none);
			word_t e_dg;
			bit e_none;
			if (want_digest.size() == 0) begin
				$display("%0t: unexpected digest %08h no_algorithm %0b", $time, dg, none);
				errors++;
				return;
			end
			e_dg = want_digest.pop_front();
			e_none = want_none.pop_front();
			if (dg !== e_dg) begin
				$display("%0t: digest expected %08h actual %08h", $time, e_dg, dg);
				errors++;
			end
			if (none !== e_none) begin
				$display("%0t: no_algorithm expected %0b actual %0b", $time, e_none, none);
				errors++;
			end
		endfunction

		function int pending();
			return want_digest.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	macc_in_if  src_if ();
	macc_out_if dst_if ();
	macc_cfg_if cfg_if ();

	multi_algorithm_checksum_engine_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if.sink),
		.dst    (dst_if.source),
		.cfg    (cfg_if.sink)
	);

	digest_scoreboard sb = new();

	// idling enables per phase; the hold request is served by the receiver
	bit src_idle_en;
	bit dst_idle_en;
	bit hold_req;
	int bytes_sent;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard limit: far above the slowest legal run.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offer one byte after an optional gap and hold it until accepted.
	// Valid is lowered only when a gap follows, so a back-to-back beat
	// never sees valid dropped and raised in the same step.
	task automatic send_byte(input logic [7:0] b, input bit last);
		int gap;
		gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			src_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_if.valid <= 1'b1;
		src_if.data_byte <= b;
		src_if.last <= last;
		do @(posedge clk); while (!src_if.ready);
		sb.take_byte(b, last);
		bytes_sent++;
	endtask

	// One message: fill 0 random, 1 all zero, 2 all ones.
	task automatic send_msg(input int len, input int fill);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	// Drop valid and wait until every digest is in, then let the
	// engine finish any tail work before the next register write.
	task automatic drain();
		int n;
		n = 0;
		src_if.valid <= 1'b0;
		while (sb.pending() > 0 && n < 500000) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input word_t v);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, v);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(input alg_t a, input word_t sv, input bit use_sv);
		write_reg(REG_ALGORITHM, word_t'(a));
		write_reg(REG_START, sv);
		write_reg(REG_USE_START, word_t'(use_sv));
	endtask

	// Receiver: random stall per beat, plus one long hold on request
	// while the sender keeps offering bytes.
	initial begin
		int gap;
		dst_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				dst_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = dst_idle_en ? $urandom_range(0, MAX_GAP) : 0;
				if (gap > 0) begin
					dst_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			dst_if.ready <= 1'b1;
			do @(posedge clk); while (!dst_if.valid);
			sb.check(dst_if.digest, dst_if.no_algorithm);
		end
	end

	initial begin
		alg_t a;
		word_t sv;
		int len;
		int msgs;
		bit pressed;
		src_if.valid <= 1'b0;
		src_if.data_byte <= '0;
		src_if.last <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_ALGORITHM;
		cfg_if.data <= '0;
		src_idle_en = 1'b0;
		dst_idle_en = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		pressed = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: out of reset no algorithm is selected, digest 0 with flag.
		send_msg(1, 2);
		send_msg(2, 0);
		drain();
		// Adler from default start, then a start whose low half sits
		// above the modulus, then all ones.
		setup(ALG_ADLER, 32'h0, 1'b0);
		send_msg(1, 2);
		send_msg(3, 1);
		drain();
		setup(ALG_ADLER, 32'hFFF0FFF5, 1'b1);
		send_msg(1, 1);
		drain();
		write_reg(REG_START, 32'hFFFFFFFF);
		send_msg(1, 2);
		drain();
		// CRC default and from start value FFFFFFFF
		setup(ALG_CRC, 32'hFFFFFFFF, 1'b0);
		send_msg(1, 2);
		drain();
		write_reg(REG_USE_START, 32'd1);
		send_msg(2, 0);
		drain();
		// xxHash32: no stripe, tail words and bytes, exact and past a stripe.
		// The spare index must leave the configuration untouched.
		setup(ALG_XXH, 32'h0, 1'b0);
		write_reg(REG_SPARE, 32'h5A5A5A5A);
		send_msg(1, 2);
		send_msg(4, 0);
		send_msg(16, 0);
		send_msg(17, 2);
		drain();
		write_reg(REG_START, 32'hFFFFFFFF);
		send_msg(20, 0);
		drain();

		// Random phases: new settings, random idling, a few messages each.
		while (bytes_sent < 1350) begin
			a = alg_t'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: sv = 32'h0;
				1: sv = 32'hFFFFFFFF;
				default: sv = $urandom;
			endcase
			setup(a, sv, $urandom_range(0, 1));
			src_idle_en = $urandom_range(0, 3) != 0;
			dst_idle_en = $urandom_range(0, 3) != 0;
			msgs = $urandom_range(2, 10);
			for (int m = 0; m < msgs; m++) begin
				// one long receiver hold while a long xxHash message flows
				if (!pressed && a == ALG_XXH) begin
					pressed = 1'b1;
					hold_req = 1'b1;
					src_idle_en = 1'b0;
					send_msg(40, 0);
					send_msg(3, 0);
					send_msg(2, 0);
				end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 70)
					: $urandom_range(1, 40);
				send_msg(len, 0);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else begin
			if (sb.pending() != 0)
				$display("%0t: %0d digests never arrived", $time, sb.pending());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
